>>> rtl/stcid_pkg.sv
// Shared constants, register codes and sequencer states for the smoke detector core.
package stcid_pkg;

    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS       = 16;
    localparam int LEVEL_W         = 31;
    localparam int CFG_ADDR_W      = 5;

    localparam logic [31:0] BASELINE_RST  = 32'd278528;
    localparam logic [31:0] ERR_LIMIT_RST = 32'd139264;
    localparam logic [31:0] DET_THR_RST   = 32'd69632;
    localparam logic [31:0] IR_CEIL_RST   = 32'd78643;
    localparam logic [15:0] SCALE_RST     = 16'd6554;
    localparam logic [15:0] GAIN_RST      = 16'd13107;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_EVAL  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        REG_BASELINE  = 3'd0,
        REG_ERR_LIMIT = 3'd1,
        REG_DET_THR   = 3'd2,
        REG_IR_CEIL   = 3'd3,
        REG_SCALE     = 3'd4,
        REG_GAIN      = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_DIV,
        S_E_LO,
        S_E_HI,
        S_E_ERR,
        S_E_GAIN,
        S_E_ACC,
        S_DONE
    } t_state;

endpackage

>>> rtl/stcid_ram.sv
// Generic simple dual-port RAM with registered read.
module stcid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

>>> rtl/smoke_two_channel_integrating_detector_core.sv
// Two-channel smoke detector core: moving averages, clamped error integrators, detect latch.
//
//  channel | direction | handshake                 | beat contents
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | action, ir_sample, blue_sample
//  out     | output    | o_out_valid / i_out_ready | smoke_detected, ir/blue mean, ir/blue level
//  cfg     | input     | psel/penable/pwrite/pready| six registers at paddr 4*i
//
// Push: a constant reciprocal multiply gives the integer part of each mean, the remainder picks
// the fraction from a small table. Evaluate: five steps per channel through one shared multiplier.
// Each result becomes valid in the same cycle as the input side is ready again.
// One item at a time; a new item is taken while a finished result waits in the output
// register, and its result waits in the done state until that register frees up.
// Synchronous active-low reset; window store needs no clearing pass (wrap flag masks it).
module smoke_two_channel_integrating_detector_core #(
    parameter int WINDOW      = stcid_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = stcid_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_action,
    input  logic [15:0]                      i_ir_sample,
    input  logic [15:0]                      i_blue_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_smoke_detected,
    output logic [15:0]                      o_ir_mean,
    output logic [15:0]                      o_blue_mean,
    output logic [stcid_pkg::LEVEL_W-1:0]    o_ir_level,
    output logic [stcid_pkg::LEVEL_W-1:0]    o_blue_level,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [stcid_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import stcid_pkg::*;

    localparam int PW     = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int D_W    = SUM_W + FRAC_BITS;
    localparam int CW     = 1;
    localparam int MA_W   = (SUM_W + 1 > 33) ? SUM_W + 1 : 33;
    localparam int PROD_W = MA_W + 17;
    localparam int SC_W   = SUM_W + 17;
    localparam int DIFF_W = ((SC_W > 32) ? SC_W : 32) + 1;
    localparam int ACC_W  = 35;
    // floor(sum / WINDOW) = (sum * RECIP) >> RSH for every sum below 2**SUM_W
    localparam int RSH    = SUM_W + PW;
    localparam int RCP_W  = SUM_W + 2;
    localparam int QP_W   = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // fraction of the mean for a given remainder: floor(rem * 2**16 / WINDOW)
    function automatic logic [FRAC_BITS-1:0] frac_of(input logic [PW-1:0] r);
        logic [FRAC_BITS-1:0] f;
        f = '0;
        for (int k = 0; k < WINDOW; k++) begin
            if (r == PW'(k)) begin
                f = FRAC_BITS'((k << FRAC_BITS) / WINDOW);
            end
        end
        return f;
    endfunction

    // configuration
    logic [31:0] r_baseline, r_err_limit, r_det_thr, r_ir_ceil;
    logic [15:0] r_scale, r_gain;

    // control and state
    t_state                 r_state, n_state;
    logic [PW-1:0]          r_pos;
    logic                   r_full;
    logic [SUM_W-1:0]       r_ir_sum, r_bl_sum;
    logic [D_W-1:0]         r_dq_ir, r_dq_bl;
    logic [CW-1:0]          r_cnt;
    logic                   r_ch;
    logic [LEVEL_W-1:0]     r_ir_integ, r_bl_integ;
    logic                   r_flag;
    logic                   r_out_valid;

    // payload
    logic [SAMPLE_BITS-1:0] r_ir_s, r_bl_s;
    logic signed [PROD_W-1:0] r_prod;
    logic [15:0]            r_frac;
    logic signed [32:0]     r_err;
    logic                   r_o_det;
    logic [15:0]            r_o_irm, r_o_blm;
    logic [LEVEL_W-1:0]     r_o_irl, r_o_bll;

    logic in_acc, out_acc, cfg_wr, capture;
    logic [2*SAMPLE_BITS-1:0] ram_rdata;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = r_out_valid && i_out_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign capture = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_smoke_detected = r_o_det;
    assign o_ir_mean        = r_o_irm;
    assign o_blue_mean      = r_o_blm;
    assign o_ir_level       = r_o_irl;
    assign o_blue_level     = r_o_bll;
    assign pready           = 1'b1;

    // ---------------- configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline  <= BASELINE_RST;
            r_err_limit <= ERR_LIMIT_RST;
            r_det_thr   <= DET_THR_RST;
            r_ir_ceil   <= IR_CEIL_RST;
            r_scale     <= SCALE_RST;
            r_gain      <= GAIN_RST;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[CFG_ADDR_W-1:2]))
                REG_BASELINE:  r_baseline  <= pwdata;
                REG_ERR_LIMIT: r_err_limit <= pwdata;
                REG_DET_THR:   r_det_thr   <= pwdata;
                REG_IR_CEIL:   r_ir_ceil   <= pwdata;
                REG_SCALE:     r_scale     <= pwdata[15:0];
                REG_GAIN:      r_gain      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[CFG_ADDR_W-1:2]))
            REG_BASELINE:  prdata = r_baseline;
            REG_ERR_LIMIT: prdata = r_err_limit;
            REG_DET_THR:   prdata = r_det_thr;
            REG_IR_CEIL:   prdata = r_ir_ceil;
            REG_SCALE:     prdata = {16'h0000, r_scale};
            REG_GAIN:      prdata = {16'h0000, r_gain};
            default:       prdata = 32'h0000_0000;
        endcase
    end

    // ---------------- sample window store (both channels in one word)
    stcid_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (r_state == S_UPD),
        .i_waddr (r_pos),
        .i_wdata ({r_ir_s, r_bl_s}),
        .i_re    (in_acc && (i_action == ACT_PUSH)),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // entries are only read after they were written once the ring has wrapped
    logic [SAMPLE_BITS-1:0] old_ir, old_bl;
    logic [SUM_W-1:0]       ir_sum_new, bl_sum_new;
    assign old_ir     = r_full ? ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign old_bl     = r_full ? ram_rdata[SAMPLE_BITS-1:0] : '0;
    assign ir_sum_new = r_ir_sum - SUM_W'(old_ir) + SUM_W'(r_ir_s);
    assign bl_sum_new = r_bl_sum - SUM_W'(old_bl) + SUM_W'(r_bl_s);

    // ---------------- mean by WINDOW, two lanes: quotient first, then fraction
    logic [QP_W-1:0]      qp_ir, qp_bl;
    logic [SUM_W-1:0]     q_ir, q_bl, rem_ir, rem_bl;
    logic [FRAC_BITS-1:0] fr_ir, fr_bl;
    always_comb begin
        qp_ir  = QP_W'(r_ir_sum) * QP_W'(RECIP);
        qp_bl  = QP_W'(r_bl_sum) * QP_W'(RECIP);
        q_ir   = SUM_W'(qp_ir >> RSH);
        q_bl   = SUM_W'(qp_bl >> RSH);
        // quotient already sits in the upper bits of r_dq_*
        rem_ir = r_ir_sum - r_dq_ir[D_W-1:FRAC_BITS] * SUM_W'(WINDOW);
        rem_bl = r_bl_sum - r_dq_bl[D_W-1:FRAC_BITS] * SUM_W'(WINDOW);
        fr_ir  = frac_of(rem_ir[PW-1:0]);
        fr_bl  = frac_of(rem_bl[PW-1:0]);
    end

    // ---------------- shared multiplier and evaluate datapath
    logic [D_W-1:0]            mfx;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [16:0]        mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [SC_W-1:0]           scaled;
    logic signed [DIFF_W-1:0]  diff, lim, err_c;
    logic signed [32:0]        step;
    logic signed [ACC_W-1:0]   acc, acc_c, ceil_s;
    logic [LEVEL_W-1:0]        integ_sel, integ_new;

    assign mfx = r_ch ? r_dq_bl : r_dq_ir;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_E_LO: begin
                mul_a = MA_W'(mfx[FRAC_BITS-1:0]);
                mul_b = 17'(r_scale);
            end
            S_E_HI: begin
                mul_a = MA_W'(mfx[D_W-1:FRAC_BITS]);
                mul_b = 17'(r_scale);
            end
            S_E_GAIN: begin
                mul_a = MA_W'(r_err);
                mul_b = 17'(r_gain);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        scaled    = SC_W'(r_prod[SC_W-2:0]) + SC_W'(r_frac);
        diff      = $signed(DIFF_W'(scaled)) - $signed(DIFF_W'(r_baseline));
        lim       = $signed(DIFF_W'(r_err_limit));
        err_c     = (diff > lim) ? lim : diff;
        step      = r_prod[48:16];
        integ_sel = r_ch ? r_bl_integ : r_ir_integ;
        acc       = $signed(ACC_W'(integ_sel)) + step;
        ceil_s    = $signed(ACC_W'(r_ir_ceil));
        acc_c     = (!r_ch && (acc > ceil_s)) ? ceil_s : acc;
        if (acc_c < 0) begin
            integ_new = '0;
        end else if (acc_c > $signed(ACC_W'(LEVEL_MAX))) begin
            integ_new = LEVEL_MAX;
        end else begin
            integ_new = acc_c[LEVEL_W-1:0];
        end
    end

    function automatic logic [15:0] sat_mean(input logic [D_W-1:0] q);
        logic [D_W-1:0] hx;
        hx = D_W'(q[D_W-1:FRAC_BITS]);
        return (|hx[D_W-1:16]) ? 16'hFFFF : hx[15:0];
    endfunction

    // ---------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_action)
                        ACT_PUSH: n_state = S_UPD;
                        ACT_EVAL: n_state = S_E_LO;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_UPD:    n_state = S_DIV;
            S_DIV:    n_state = (r_cnt == '0) ? S_DONE : S_DIV;
            S_E_LO:   n_state = S_E_HI;
            S_E_HI:   n_state = S_E_ERR;
            S_E_ERR:  n_state = S_E_GAIN;
            S_E_GAIN: n_state = S_E_ACC;
            S_E_ACC:  n_state = r_ch ? S_DONE : S_E_LO;
            S_DONE:   n_state = capture ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_ir_sum    <= '0;
            r_bl_sum    <= '0;
            r_dq_ir     <= '0;
            r_dq_bl     <= '0;
            r_cnt       <= '0;
            r_ch        <= 1'b0;
            r_ir_integ  <= '0;
            r_bl_integ  <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_ch <= 1'b0;
                    if (in_acc && (i_action == ACT_CLEAR)) begin
                        r_ir_integ <= '0;
                        r_bl_integ <= '0;
                        r_flag     <= 1'b0;
                    end
                end
                S_UPD: begin
                    r_ir_sum <= ir_sum_new;
                    r_bl_sum <= bl_sum_new;
                    r_cnt    <= CW'(1);
                    if (r_pos == PW'(WINDOW - 1)) begin
                        r_pos  <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_dq_ir <= {q_ir, {FRAC_BITS{1'b0}}};
                        r_dq_bl <= {q_bl, {FRAC_BITS{1'b0}}};
                    end else begin
                        r_dq_ir <= {r_dq_ir[D_W-1:FRAC_BITS], fr_ir};
                        r_dq_bl <= {r_dq_bl[D_W-1:FRAC_BITS], fr_bl};
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
                S_E_ACC: begin
                    if (r_ch) begin
                        r_bl_integ <= integ_new;
                    end else begin
                        r_ir_integ <= integ_new;
                        if ({1'b0, integ_new} > r_det_thr) begin
                            r_flag <= 1'b1;
                        end
                    end
                    r_ch <= 1'b1;
                end
                default: ;
            endcase

            if (capture) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ir_s <= SAMPLE_BITS'(i_ir_sample);
            r_bl_s <= SAMPLE_BITS'(i_blue_sample);
        end
        if (r_state == S_E_LO || r_state == S_E_HI || r_state == S_E_GAIN) begin
            r_prod <= mul_p;
        end
        if (r_state == S_E_HI) begin
            r_frac <= r_prod[31:16];
        end
        if (r_state == S_E_ERR) begin
            r_err <= err_c[32:0];
        end
        if (capture) begin
            r_o_det <= r_flag;
            r_o_irm <= sat_mean(r_dq_ir);
            r_o_blm <= sat_mean(r_dq_bl);
            r_o_irl <= r_ir_integ;
            r_o_bll <= r_bl_integ;
        end
    end
endmodule

>>> rtl/stcid_checker.sv
// Port-level checks for the smoke detector core, bound to the top level.
module stcid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_smoke_detected,
    input logic [15:0] o_ir_mean,
    input logic [30:0] o_ir_level,
    input logic [30:0] o_blue_level,
    input logic        pready
);
    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready did not drop after an accepted beat");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_ir_level)
            && $stable(o_blue_level) && $stable(o_ir_mean) && $stable(o_smoke_detected)))
        else $error("stalled result beat changed");
endmodule

bind smoke_two_channel_integrating_detector_core stcid_checker u_stcid_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_smoke_detected (o_smoke_detected),
    .o_ir_mean        (o_ir_mean),
    .o_ir_level       (o_ir_level),
    .o_blue_level     (o_blue_level),
    .pready           (pready)
);
